/* rtl/fwsm_pkg.sv */
// ----------------------------------------------------------------------------
// fwsm_pkg
// Shared constants and types for the flapping-wing servo mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package fwsm_pkg;

  // phase accumulator and sine lookup resolution
  localparam int PHASE_W      = 16;
  localparam int SINE_ENTRIES = 1024;
  localparam int TBL_W        = $clog2(SINE_ENTRIES);

  // shared multiplier
  localparam int MUL_W  = 24;
  localparam int PROD_W = 2 * MUL_W;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_GAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REAR_SCALE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REAR_LAG   = 3'd6;

  // reciprocal multipliers: floor(y/125) = (y*M125)>>26 for y < 2^19,
  // floor(y/225) = (y*M225)>>28 for y < 2^20
  localparam logic [MUL_W-1:0] DIV125_MUL = 24'd536871;
  localparam logic [MUL_W-1:0] DIV225_MUL = 24'd1193047;

  // sine polynomial coefficients, Q14
  localparam logic [14:0] SIN_A = 15'd25736;
  localparam logic [13:0] SIN_B = 14'd10512;
  localparam logic [10:0] SIN_C = 11'd1160;

  // post-multiply shift: R = round half up, T = truncate
  typedef enum logic [2:0] {
    SH_R8,
    SH_R12,
    SH_R14,
    SH_T14,
    SH_T26,
    SH_T28
  } shift_t;

  typedef struct packed {
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
    shift_t           sh;
  } mul_req_t;

endpackage

`default_nettype wire

/* rtl/flapping_wing_servo_mixer_core.sv */
// The block takes no new request until it has registered the last result; the
// twenty multiplies of one tick run through the single shared multiplier, each
// issuing its operands and then writing back the registered product.
// A result waiting on out_stall holds the block in its final state and so holds the next request.
// Reset (synchronous, rst_n low): registers to defaults, flap phase to zero,
// no result pending.
// ----------------------------------------------------------------------------
// flapping_wing_servo_mixer_core
// Stick parsing, phase accumulation, sine and servo mixing on one multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module flapping_wing_servo_mixer_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [fwsm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [fwsm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [11:0]                    in_steer_pulse,
  input  logic                           in_steer_valid,
  input  logic [11:0]                    in_pitch_pulse,
  input  logic                           in_pitch_valid,
  input  logic [11:0]                    in_throttle_pulse,
  input  logic                           in_throttle_valid,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [15:0]                    out_right_front_angle,
  output logic [15:0]                    out_left_front_angle,
  output logic [15:0]                    out_right_rear_angle,
  output logic [15:0]                    out_left_rear_angle
);
  import fwsm_pkg::*;

  localparam logic [10:0] STICK_MIN   = 11'd1000;
  localparam logic [10:0] STICK_MAX   = 11'd2000;
  localparam logic [10:0] STICK_MID   = 11'd1500;
  localparam logic [8:0]  DEAD_BAND   = 9'd30;
  localparam logic [10:0] THR_MIN     = 11'd1050;
  localparam logic [10:0] THR_MAX     = 11'd1950;
  localparam logic [12:0] UNITY_Q12   = 13'd4096;
  localparam logic signed [19:0] ANGLE_MAX = 20'sd46080;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_OUT} state_t;

  typedef enum logic [3:0] {
    SP_DIV_STEER, SP_DIV_PITCH, SP_DIV_THR, SP_PH_STEP, SP_BASE,
    SP_PGAIN, SP_FAMP, SP_RAMP0, SP_RAMP, SP_OFFS,
    SP_Z2, SP_T1, SP_T2, SP_SIN, SP_APPLY
  } step_t;

  typedef struct packed {
    logic        neg;
    logic [18:0] y;
  } stick_t;

  // clamp, centre and dead band; y = (|d|*4096 + 250) >> 2, ready for /125
  function automatic stick_t parse_stick(input logic [11:0] pulse, input logic valid);
    logic [10:0] pc;
    logic [8:0]  mag;
    stick_t      o;
    if (pulse < 12'(STICK_MIN)) pc = STICK_MIN;
    else if (pulse > 12'(STICK_MAX)) pc = STICK_MAX;
    else pc = pulse[10:0];
    o.neg = pc < STICK_MID;
    mag   = o.neg ? 9'(STICK_MID - pc) : 9'(pc - STICK_MID);
    o.y   = (!valid || mag < DEAD_BAND) ? '0 : {mag, 10'b0} + 19'd62;
    return o;
  endfunction

  // y = ((p-1050)*4096 + 450) >> 2, ready for /225
  function automatic logic [19:0] parse_thr(input logic [11:0] pulse, input logic valid);
    logic [10:0] pc;
    logic [9:0]  d;
    logic [19:0] y;
    pc = (pulse > 12'(THR_MAX)) ? THR_MAX : pulse[10:0];
    d  = 10'(pc - THR_MIN);
    y  = (!valid || pulse < 12'(THR_MIN)) ? '0 : {d, 10'b0} + 20'd112;
    return y;
  endfunction

  // 1/65536-of-a-flap-period units to PHASE_W-bit units
  function automatic logic [PHASE_W-1:0] to_units(input logic [15:0] v);
    logic [PHASE_W+15:0] w;
    w = {{PHASE_W{1'b0}}, v} << PHASE_W;
    return w[PHASE_W+15:16];
  endfunction

  function automatic logic [15:0] sat_angle(input logic signed [19:0] v);
    logic [15:0] o;
    if (v < 0) o = '0;
    else if (v > ANGLE_MAX) o = 16'(ANGLE_MAX);
    else o = v[15:0];
    return o;
  endfunction

  // configuration registers
  logic [15:0] center_r;
  logic [13:0] phase_step_r;
  logic [14:0] amplitude_r;
  logic [13:0] steer_gain_r;
  logic [7:0]  pitch_gain_r;
  logic [7:0]  rear_scale_r;
  logic [15:0] rear_lag_r;

  // control
  state_t state_r;
  step_t  step_r, step_nxt;
  logic   wr_r;
  logic   sel_r;
  logic   out_valid_r;
  logic [PHASE_W-1:0] flap_phase_r, phase_nxt;

  // datapath
  logic [18:0] steer_y_r, pitch_y_r;
  logic [19:0] thr_y_r;
  logic        steer_neg_r, pitch_neg_r;
  logic [12:0] steer_mag_r, pitch_mag_r, thr_r, pmag_r;
  logic [14:0] base_r;
  logic [16:0] famp_r, ramp_r;
  logic [13:0] offs_r;
  logic [14:0] z2_r;
  logic [13:0] tb_r;
  logic [14:0] ta_r;
  logic [15:0] s_r;
  logic [16:0] fs_mag_r, rs_mag_r;
  logic        fs_neg_r, rs_neg_r;
  logic [15:0] rf_r, lf_r, rr_r, lr_r;

  logic        in_acc;
  stick_t      steer_p, pitch_p;
  logic [19:0] thr_y;

  logic [PHASE_W-1:0] rear_ph, sin_ph;
  logic [TBL_W-1:0]   idx, rl;
  logic [1:0]         quad;
  logic [TBL_W:0]     r;
  logic [14:0]        z;
  logic [12:0]        ffac, rfac;

  mul_req_t         req;
  logic [MUL_W-1:0] res;

  logic signed [19:0] c_s, off_s, fs_s, rs_s;
  logic signed [19:0] rf_s, lf_s, rr_s, lr_s;
  logic               out_free;

  fwsm_mul_unit u_mul (
    .clk (clk),
    .req (req),
    .res (res)
  );

  assign in_acc  = in_valid && !in_stall;
  assign steer_p = parse_stick(in_steer_pulse, in_steer_valid);
  assign pitch_p = parse_stick(in_pitch_pulse, in_pitch_valid);
  assign thr_y   = parse_thr(in_throttle_pulse, in_throttle_valid);

  // quarter-wave folding of the table index
  assign rear_ph = flap_phase_r - to_units(rear_lag_r);
  assign sin_ph  = sel_r ? rear_ph : flap_phase_r;
  assign idx     = sin_ph[PHASE_W-1 -: TBL_W];
  assign quad    = idx[TBL_W-1 -: 2];
  assign rl      = {idx[TBL_W-3:0], 2'b00};
  assign r       = quad[0] ? (TBL_W+1)'(SINE_ENTRIES) - {1'b0, rl} : {1'b0, rl};
  assign z       = 15'(r) << (14 - TBL_W);

  assign ffac = pitch_neg_r ? UNITY_Q12 + pmag_r : UNITY_Q12 - pmag_r;
  assign rfac = pitch_neg_r ? UNITY_Q12 - pmag_r : UNITY_Q12 + pmag_r;

  assign phase_nxt = flap_phase_r + to_units(res[15:0]);

  always_comb begin
    req    = '0;
    req.sh = SH_T14;
    case (step_r)
      SP_DIV_STEER: begin req.a = MUL_W'(steer_y_r); req.b = DIV125_MUL; req.sh = SH_T26; end
      SP_DIV_PITCH: begin req.a = MUL_W'(pitch_y_r); req.b = DIV125_MUL; req.sh = SH_T26; end
      SP_DIV_THR:   begin req.a = MUL_W'(thr_y_r); req.b = DIV225_MUL; req.sh = SH_T28; end
      SP_PH_STEP: begin
        req.a = MUL_W'(thr_r); req.b = MUL_W'(phase_step_r); req.sh = SH_R12;
      end
      SP_BASE: begin
        req.a = MUL_W'(thr_r); req.b = MUL_W'(amplitude_r); req.sh = SH_R12;
      end
      SP_PGAIN: begin
        req.a = MUL_W'(pitch_mag_r); req.b = MUL_W'(pitch_gain_r); req.sh = SH_R8;
      end
      SP_FAMP:  begin req.a = MUL_W'(base_r); req.b = MUL_W'(ffac); req.sh = SH_R12; end
      SP_RAMP0: begin req.a = MUL_W'(base_r); req.b = MUL_W'(rfac); req.sh = SH_R12; end
      SP_RAMP: begin
        req.a = MUL_W'(ramp_r); req.b = MUL_W'(rear_scale_r); req.sh = SH_R8;
      end
      SP_OFFS: begin
        req.a = MUL_W'(steer_mag_r); req.b = MUL_W'(steer_gain_r); req.sh = SH_R12;
      end
      SP_Z2:  begin req.a = MUL_W'(z); req.b = MUL_W'(z); req.sh = SH_T14; end
      SP_T1:  begin req.a = MUL_W'(SIN_C); req.b = MUL_W'(z2_r); req.sh = SH_T14; end
      SP_T2:  begin req.a = MUL_W'(z2_r); req.b = MUL_W'(tb_r); req.sh = SH_T14; end
      SP_SIN: begin req.a = MUL_W'(z); req.b = MUL_W'(ta_r); req.sh = SH_T14; end
      SP_APPLY:     begin
        req.a  = MUL_W'(s_r);
        req.b  = sel_r ? MUL_W'(ramp_r) : MUL_W'(famp_r);
        req.sh = SH_R14;
      end
      default: req = '0;
    endcase
  end

  always_comb begin
    case (step_r)
      SP_DIV_STEER: step_nxt = SP_DIV_PITCH;
      SP_DIV_PITCH: step_nxt = SP_DIV_THR;
      SP_DIV_THR:   step_nxt = SP_PH_STEP;
      SP_PH_STEP:   step_nxt = SP_BASE;
      SP_BASE:      step_nxt = SP_PGAIN;
      SP_PGAIN:     step_nxt = SP_FAMP;
      SP_FAMP:      step_nxt = SP_RAMP0;
      SP_RAMP0:     step_nxt = SP_RAMP;
      SP_RAMP:      step_nxt = SP_OFFS;
      SP_OFFS:      step_nxt = SP_Z2;
      SP_Z2:        step_nxt = SP_T1;
      SP_T1:        step_nxt = SP_T2;
      SP_T2:        step_nxt = SP_SIN;
      SP_SIN:       step_nxt = SP_APPLY;
      SP_APPLY:     step_nxt = SP_Z2;
      default:      step_nxt = SP_DIV_STEER;
    endcase
  end

  // final mix
  assign c_s   = 20'(center_r);
  assign off_s = steer_neg_r ? -20'(offs_r) : 20'(offs_r);
  assign fs_s  = fs_neg_r ? -20'(fs_mag_r) : 20'(fs_mag_r);
  assign rs_s  = rs_neg_r ? -20'(rs_mag_r) : 20'(rs_mag_r);
  assign rf_s  = c_s + off_s + fs_s;
  assign lf_s  = c_s - off_s - fs_s;
  assign rr_s  = c_s + off_s + rs_s;
  assign lr_s  = c_s - off_s - rs_s;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= SP_DIV_STEER;
      wr_r         <= 1'b0;
      sel_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      flap_phase_r <= '0;
      center_r     <= 16'd23040;
      phase_step_r <= 14'd5898;
      amplitude_r  <= 15'd11520;
      steer_gain_r <= 14'd5120;
      pitch_gain_r <= 8'd102;
      rear_scale_r <= 8'd166;
      rear_lag_r   <= 16'd13107;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_CENTER:     center_r     <= cfg_wdata;
          CFG_PHASE_STEP: phase_step_r <= cfg_wdata[13:0];
          CFG_AMPLITUDE:  amplitude_r  <= cfg_wdata[14:0];
          CFG_STEER_GAIN: steer_gain_r <= cfg_wdata[13:0];
          CFG_PITCH_GAIN: pitch_gain_r <= cfg_wdata[7:0];
          CFG_REAR_SCALE: rear_scale_r <= cfg_wdata[7:0];
          CFG_REAR_LAG:   rear_lag_r   <= cfg_wdata;
          default: ;
        endcase
      end

      // a new result may replace one taken in the same cycle
      if (state_r == ST_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            steer_y_r   <= steer_p.y;
            steer_neg_r <= steer_p.neg;
            pitch_y_r   <= pitch_p.y;
            pitch_neg_r <= pitch_p.neg;
            thr_y_r     <= thr_y;
            step_r      <= SP_DIV_STEER;
            wr_r        <= 1'b0;
            sel_r       <= 1'b0;
            state_r     <= ST_RUN;
          end
        end
        ST_RUN: begin
          wr_r <= !wr_r;
          // odd cycle: product registered, write back and move on
          if (wr_r) begin
            step_r <= step_nxt;
            case (step_r)
              SP_DIV_STEER: steer_mag_r  <= res[12:0];
              SP_DIV_PITCH: pitch_mag_r  <= res[12:0];
              SP_DIV_THR:   thr_r        <= res[12:0];
              SP_PH_STEP:   flap_phase_r <= phase_nxt;
              SP_BASE:      base_r       <= res[14:0];
              SP_PGAIN:     pmag_r       <= res[12:0];
              SP_FAMP:      famp_r       <= res[16:0];
              SP_RAMP0:     ramp_r       <= res[16:0];
              SP_RAMP:      ramp_r       <= res[16:0];
              SP_OFFS:      offs_r       <= res[13:0];
              SP_Z2:        z2_r         <= res[14:0];
              SP_T1:        tb_r         <= SIN_B - res[13:0];
              SP_T2:        ta_r         <= SIN_A - res[14:0];
              SP_SIN:       s_r          <= res[15:0];
              SP_APPLY: begin
                if (sel_r) begin
                  rs_mag_r <= res[16:0];
                  rs_neg_r <= quad[1];
                  state_r  <= ST_OUT;
                end else begin
                  fs_mag_r <= res[16:0];
                  fs_neg_r <= quad[1];
                end
                sel_r <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_OUT: begin
          if (out_free) begin
            rf_r    <= sat_angle(rf_s);
            lf_r    <= sat_angle(lf_s);
            rr_r    <= sat_angle(rr_s);
            lr_r    <= sat_angle(lr_s);
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall              = (state_r != ST_IDLE);
  assign out_valid             = out_valid_r;
  assign out_right_front_angle = rf_r;
  assign out_left_front_angle  = lf_r;
  assign out_right_rear_angle  = rr_r;
  assign out_left_rear_angle   = lr_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("request accepted but block not busy");

  a_result_from_mix: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result shown without final mix");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (rf_r <= 16'd46080 && lf_r <= 16'd46080 &&
                     rr_r <= 16'd46080 && lr_r <= 16'd46080))
    else $error("servo angle beyond 180 degrees");

  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r == ST_RUN && step_r == SP_PH_STEP && wr_r) |=> $stable(flap_phase_r))
    else $error("flap phase moved outside its update step");

endmodule

`default_nettype wire

/* rtl/fwsm_mul_unit.sv */
// ----------------------------------------------------------------------------
// fwsm_mul_unit
// Shared multiplier: registered product, then round or truncate by a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module fwsm_mul_unit (
  input  logic                    clk,
  input  fwsm_pkg::mul_req_t      req,
  output logic [fwsm_pkg::MUL_W-1:0] res
);
  import fwsm_pkg::*;

  localparam int SUM_W = PROD_W + 8;

  logic [PROD_W-1:0] prod_r;
  shift_t            sh_r;
  logic [SUM_W-1:0]  sum;

  always_ff @(posedge clk) begin
    prod_r <= req.a * req.b;
    sh_r   <= req.sh;
  end

  always_comb begin
    sum = {8'b0, prod_r};
    res = '0;
    case (sh_r)
      SH_R8: begin
        sum = {8'b0, prod_r} + SUM_W'(128);
        res = sum[8 +: MUL_W];
      end
      SH_R12: begin
        sum = {8'b0, prod_r} + SUM_W'(2048);
        res = sum[12 +: MUL_W];
      end
      SH_R14: begin
        sum = {8'b0, prod_r} + SUM_W'(8192);
        res = sum[14 +: MUL_W];
      end
      SH_T14: res = sum[14 +: MUL_W];
      SH_T26: res = sum[26 +: MUL_W];
      SH_T28: res = sum[28 +: MUL_W];
      default: res = '0;
    endcase
  end

endmodule

`default_nettype wire
